// File: sv/slc_pkg.sv
// Shared types, codes and constants of the text-image cache.
package slc_pkg;

  localparam int NUM_SETS_DEF = 192;
  localparam int NUM_WAYS_DEF = 4;

  localparam logic [63:0] MIX_UTF8  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_PLAIN = 64'h0000_0000_85eb_ca6b;

  localparam logic [25:0] BUDGET_RESET = 26'(32 * 1024 * 1024);
  localparam logic [9:0]  MAXLEN_RESET = 10'd512;

  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_TOO_BIG  = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [63:0] ctx;
    logic [63:0] font;
    logic [31:0] colour;
    logic        mode;
    logic [9:0]  len;
    logic [31:0] hash;
    logic [63:0] age;
    logic [13:0] w;
    logic [13:0] h;
    logic [25:0] nbytes;
  } entry_t;

endpackage

// File: sv/slc_req_if.sv
// Request channel of the text-image cache.
interface slc_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] renderer_id;
  logic [63:0] font_id;
  logic [31:0] text_colour;
  logic        utf8_mode;
  logic [9:0]  text_len;
  logic [31:0] text_digest;
  logic [13:0] image_width;
  logic [13:0] image_height;

  modport source (output valid, renderer_id, font_id, text_colour, utf8_mode, text_len,
                  text_digest, image_width, image_height, input ready);
  modport sink (input valid, renderer_id, font_id, text_colour, utf8_mode, text_len,
                text_digest, image_width, image_height, output ready);
endinterface

// File: sv/slc_res_if.sv
// Result channel of the text-image cache.
interface slc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  slot_index;
  logic [13:0] entry_width;
  logic [13:0] entry_height;
  logic [9:0]  evictions;
  logic [25:0] bytes_in_use;

  modport source (output valid, status, slot_index, entry_width, entry_height, evictions,
                  bytes_in_use, input ready);
  modport sink (input valid, status, slot_index, entry_width, entry_height, evictions,
                bytes_in_use, output ready);
endinterface

// File: sv/slc_mod_unit.sv
// Remainder of a 64-bit key by the set count, folded and reduced on one multiplier.
module slc_mod_unit #(
  parameter int MODULUS = 192,
  parameter int SW      = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   dividend,
  output logic          done,
  output logic [SW-1:0] rem
);

  // residues of the 16-bit digit weights, and a reciprocal that may read one low
  localparam logic [31:0] W0    = 32'(64'd1 % 64'(MODULUS));
  localparam logic [31:0] W1    = 32'((64'd1 << 16) % 64'(MODULUS));
  localparam logic [31:0] W2    = 32'((64'd1 << 32) % 64'(MODULUS));
  localparam logic [31:0] W3    = 32'((64'd1 << 48) % 64'(MODULUS));
  localparam logic [31:0] RECIP = 32'(64'h0000_0000_FFFF_FFFF / 64'(MODULUS));
  localparam logic [31:0] MOD32 = 32'(MODULUS);

  logic        busy;
  logic [2:0]  cnt;
  logic [63:0] shreg;
  logic [31:0] acc;
  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] rfix;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  always_comb begin
    mul_a = 32'(shreg[15:0]);
    mul_b = W0;
    case (cnt)
      3'd0: mul_b = W0;
      3'd1: mul_b = W1;
      3'd2: mul_b = W2;
      3'd3: mul_b = W3;
      3'd4: begin
        mul_a = acc;
        mul_b = RECIP;
      end
      3'd5: begin
        mul_a = q;
        mul_b = MOD32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
    rfix = (r >= MOD32) ? r - MOD32 : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        acc   <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt < 3'd4) begin
          // fold one digit, advance to the next
          acc   <= acc + prod[31:0];
          shreg <= {16'd0, shreg[63:16]};
        end else if (cnt == 3'd4) begin
          q <= prod[63:32];
        end else if (cnt == 3'd5) begin
          r <= acc - prod[31:0];
        end else begin
          rem  <= rfix[SW-1:0];
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/slc_store.sv
// Entry memory: one write port, one registered read port.
module slc_store
  import slc_pkg::*;
#(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/set_assoc_lru_cache_byte_budget_top.sv
// Set-associative LRU text-image cache held under a byte budget.
//
// Requests arrive on req (valid/ready); one result per request leaves on res.
// Configuration is a plain write port: cfg_we, cfg_index (0 byte budget,
// 1 longest text length), cfg_data; the user must see that it is written only
// while the block is idle, which the block does not enforce. After reset a
// clearing pass walks all NUM_SETS*NUM_WAYS entries of the entry memory
// (768 by default), with req.ready low. A request with a bad length goes
// straight to its result. Otherwise the set index is a remainder of the
// mixed key, folded in 16-bit digits and reduced on one shared multiplier,
// then each way is read and compared in turn. Every eviction for the
// budget adds a full scan of the entry memory, one entry a cycle; the
// single memory read port sets that rate. One request is worked on at a
// time.
// The next request may be taken while a result still waits on res; a
// request that finishes while res is stalled holds until the result is
// taken.
module set_assoc_lru_cache_byte_budget_top
  import slc_pkg::*;
#(
  parameter int NUM_SETS = NUM_SETS_DEF,
  parameter int NUM_WAYS = NUM_WAYS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  slc_req_if.sink      req,
  slc_res_if.source    res,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [25:0]  cfg_data
);

  localparam int ENTRIES = NUM_SETS * NUM_WAYS;
  localparam int EW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW      = $clog2(NUM_WAYS + 1);
  localparam int CW      = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_PRD    = 4'd3;
  localparam logic [3:0] S_PCHK   = 4'd4;
  localparam logic [3:0] S_MISS   = 4'd5;
  localparam logic [3:0] S_CHKFIT = 4'd6;
  localparam logic [3:0] S_FIT    = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_SDROP  = 4'd9;
  localparam logic [3:0] S_INSERT = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  logic [3:0]    state;
  logic [25:0]   byte_budget;
  logic [9:0]    max_text_length;
  logic [25:0]   total_bytes;
  logic [63:0]   use_counter;

  logic [63:0]   ctx_q, font_q;
  logic [31:0]   colour_q, hash_q;
  logic          mode_q;
  logic [9:0]    len_q;
  logic [13:0]   w_q, h_q;
  logic [29:0]   need_q;

  logic [EW-1:0] probe_addr;
  logic [WW-1:0] way_cnt;
  logic [EW-1:0] slot_q;
  logic          slot_valid;
  logic          have_old;
  logic [63:0]   best_age;
  logic [25:0]   slot_bytes;

  logic [CW-1:0] scan_cnt;
  logic          iss_q;
  logic [EW-1:0] iss_idx_q;
  logic          any_q;
  logic [EW-1:0] victim_q;
  logic [25:0]   victim_bytes;
  logic [9:0]    evicted;

  logic [1:0]    r_status;
  logic [9:0]    r_slot;
  logic [13:0]   r_w, r_h;
  logic [9:0]    r_ev;

  logic          res_valid;
  logic [1:0]    res_status;
  logic [9:0]    res_slot;
  logic [13:0]   res_w, res_h;
  logic [9:0]    res_ev;
  logic [25:0]   res_total;

  logic          accept;
  logic          bad_len;
  logic [63:0]   key;
  logic          mod_start;
  logic          mod_done;
  logic [SW-1:0] set_idx;
  logic [31:0]   base_wide;
  logic [31:0]   slot_wide;

  logic          we;
  logic [EW-1:0] waddr;
  entry_t        wdata;
  logic [EW-1:0] raddr;
  entry_t        rdata;

  logic          match;
  logic          older;
  logic [30:0]   fit_sum;
  logic          scan_issue;

  assign accept  = req.valid && req.ready;
  assign bad_len = (req.text_len == 10'd0) || (req.text_len > max_text_length);
  assign key     = req.renderer_id ^ {req.font_id[62:0], 1'b0} ^ {req.text_colour, 32'd0}
                 ^ {32'd0, req.text_digest} ^ (req.utf8_mode ? MIX_UTF8 : MIX_PLAIN);
  assign mod_start = accept && !bad_len;

  slc_mod_unit #(
    .MODULUS (NUM_SETS),
    .SW      (SW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (key),
    .done     (mod_done),
    .rem      (set_idx)
  );

  slc_store #(
    .DEPTH (ENTRIES),
    .AW    (EW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign base_wide = 32'(set_idx) * 32'(NUM_WAYS);
  assign slot_wide = 32'(slot_q);

  assign match = rdata.ctx == ctx_q && rdata.font == font_q && rdata.colour == colour_q
              && rdata.mode == mode_q && rdata.len == len_q && rdata.hash == hash_q;
  assign older = !have_old || (rdata.age < best_age);
  assign fit_sum = 31'(total_bytes) + 31'(need_q);
  assign scan_issue = (state == S_SCAN) && (scan_cnt < CW'(ENTRIES));

  always_comb begin
    raddr = probe_addr;
    if (state == S_SCAN) begin
      raddr = scan_cnt[EW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = scan_cnt[EW-1:0];
      end
      S_PCHK: begin
        if (rdata.valid && match) begin
          we        = 1'b1;
          waddr     = probe_addr;
          wdata     = rdata;
          wdata.age = use_counter;
        end
      end
      S_MISS: begin
        we = slot_valid;
      end
      S_SDROP: begin
        we    = any_q;
        waddr = victim_q;
      end
      S_INSERT: begin
        we           = 1'b1;
        wdata.valid  = 1'b1;
        wdata.ctx    = ctx_q;
        wdata.font   = font_q;
        wdata.colour = colour_q;
        wdata.mode   = mode_q;
        wdata.len    = len_q;
        wdata.hash   = hash_q;
        wdata.age    = use_counter - 64'd1;
        wdata.w      = w_q;
        wdata.h      = h_q;
        wdata.nbytes = need_q[25:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget     <= BUDGET_RESET;
      max_text_length <= MAXLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUDGET: byte_budget     <= cfg_data;
        CFG_MAXLEN: max_text_length <= cfg_data[9:0];
        default:    byte_budget     <= byte_budget;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_q <= 1'b0;
    end else begin
      iss_q <= scan_issue;
    end
    iss_idx_q <= scan_cnt[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      scan_cnt    <= '0;
      total_bytes <= '0;
      use_counter <= 64'd1;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt == CW'(ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ctx_q    <= req.renderer_id;
            font_q   <= req.font_id;
            colour_q <= req.text_colour;
            mode_q   <= req.utf8_mode;
            len_q    <= req.text_len;
            hash_q   <= req.text_digest;
            w_q      <= req.image_width;
            h_q      <= req.image_height;
            need_q   <= {28'(req.image_width) * 28'(req.image_height), 2'b00};
            evicted  <= '0;
            have_old <= 1'b0;
            if (bad_len) begin
              r_status <= ST_BAD;
              r_slot   <= '0;
              r_w      <= '0;
              r_h      <= '0;
              r_ev     <= '0;
              state    <= S_FINISH;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (mod_done) begin
            probe_addr <= base_wide[EW-1:0];
            way_cnt    <= '0;
            state      <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (!rdata.valid) begin
            slot_q     <= probe_addr;
            slot_valid <= 1'b0;
            state      <= S_MISS;
          end else if (match) begin
            slot_q      <= probe_addr;
            use_counter <= use_counter + 64'd1;
            r_status    <= ST_HIT;
            r_slot      <= 10'(32'(probe_addr));
            r_w         <= rdata.w;
            r_h         <= rdata.h;
            r_ev        <= '0;
            state       <= S_FINISH;
          end else begin
            if (older) begin
              slot_q     <= probe_addr;
              best_age   <= rdata.age;
              slot_bytes <= rdata.nbytes;
              have_old   <= 1'b1;
            end
            if (way_cnt == WW'(NUM_WAYS - 1)) begin
              slot_valid <= 1'b1;
              state      <= S_MISS;
            end else begin
              probe_addr <= probe_addr + EW'(1);
              way_cnt    <= way_cnt + WW'(1);
              state      <= S_PRD;
            end
          end
        end
        S_MISS: begin
          // drop the replaced entry, clamp the total at zero
          if (slot_valid) begin
            total_bytes <= (total_bytes >= slot_bytes) ? total_bytes - slot_bytes : '0;
          end
          use_counter <= use_counter + 64'd1;
          state       <= S_CHKFIT;
        end
        S_CHKFIT: begin
          if (need_q > 30'(byte_budget)) begin
            r_status <= ST_TOO_BIG;
            r_slot   <= slot_wide[9:0];
            r_w      <= '0;
            r_h      <= '0;
            r_ev     <= '0;
            state    <= S_FINISH;
          end else begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (fit_sum > 31'(byte_budget)) begin
            scan_cnt <= '0;
            any_q    <= 1'b0;
            state    <= S_SCAN;
          end else begin
            state <= S_INSERT;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            scan_cnt <= scan_cnt + CW'(1);
          end
          if (iss_q && rdata.valid && (!any_q || rdata.age < best_age)) begin
            victim_q     <= iss_idx_q;
            best_age     <= rdata.age;
            victim_bytes <= rdata.nbytes;
            any_q        <= 1'b1;
          end
          if (!scan_issue && !iss_q) begin
            state <= S_SDROP;
          end
        end
        S_SDROP: begin
          if (any_q) begin
            total_bytes <= (total_bytes >= victim_bytes) ? total_bytes - victim_bytes : '0;
            evicted     <= evicted + 10'd1;
            state       <= S_FIT;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          total_bytes <= fit_sum[25:0];
          r_status    <= ST_INSERTED;
          r_slot      <= slot_wide[9:0];
          r_w         <= w_q;
          r_h         <= h_q;
          r_ev        <= evicted;
          state       <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the result register is free
          if (!res_valid || res.ready) begin
            res_valid  <= 1'b1;
            res_status <= r_status;
            res_slot   <= r_slot;
            res_w      <= r_w;
            res_h      <= r_h;
            res_ev     <= r_ev;
            res_total  <= total_bytes;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign res.valid        = res_valid;
  assign res.status       = res_status;
  assign res.slot_index   = res_slot;
  assign res.entry_width  = res_w;
  assign res.entry_height = res_h;
  assign res.evictions    = res_ev;
  assign res.bytes_in_use = res_total;

endmodule

// File: sv/slc_checker.sv
// Port-level checks of the text-image cache, bound to the top level.
module slc_checker
  import slc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_status,
  input logic [9:0]  res_slot,
  input logic [9:0]  res_ev,
  input logic [25:0] res_total
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid && !req_ready)
    else $error("result or ready raised straight after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_total))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == ST_BAD |-> res_slot == 10'd0 && res_ev == 10'd0)
    else $error("bad request reports a slot or evictions");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_HIT || res_status == ST_TOO_BIG) |-> res_ev == 10'd0)
    else $error("evictions on a hit or a rejected request");

endmodule

bind set_assoc_lru_cache_byte_budget_top slc_checker u_slc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_slot   (res.slot_index),
  .res_ev     (res.evictions),
  .res_total  (res.bytes_in_use)
);
